/* design/centered_window_average_unit_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the centered window average unit
// Concurrent checks on clock, disabled while reset is high; empty for synthesis.
// ----------------------------------------------------------------------------
`ifndef CENTERED_WINDOW_AVERAGE_UNIT_MACROS_SVH
`define CENTERED_WINDOW_AVERAGE_UNIT_MACROS_SVH

`ifndef SYNTHESIS
`define CWA_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
`define CWA_ASSERT_NEVER(label, cond, msg) \
   `CWA_ASSERT(label, !(cond), msg)
`else
`define CWA_ASSERT(label, prop, msg)
`define CWA_ASSERT_NEVER(label, cond, msg)
`endif

`endif

/* design/cwa_pkg.sv */
// ----------------------------------------------------------------------------
// Centered window average package
// Shared types and fixed constants of the centered window average unit.
// ----------------------------------------------------------------------------
package cwa_pkg;

   localparam int DIV_BITS_PER_CYCLE = 4;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_DIVIDE
   } cwa_state_type;

   typedef struct packed {
      logic push;
      logic clear;
      logic start;
      logic use_total;
      logic drop;
   } lane_ctrl_type;

   typedef struct packed {
      logic busy;
   } lane_stat_type;

   typedef struct packed {
      logic load;
      logic fin;
   } merge_ctrl_type;

endpackage

/* design/cwa_lane.sv */
// ----------------------------------------------------------------------------
// Centered window average lane
// Window shift line, running sum and digit-serial rounding divider of one channel.
// ----------------------------------------------------------------------------
`include "centered_window_average_unit_macros.svh"

module cwa_lane #(
   parameter int RADIUS       = 3,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  cwa_pkg::lane_ctrl_type               ctrl,
   input  logic [$clog2(2*RADIUS+1)-1:0]        drop_index,
   input  logic [$clog2(2*RADIUS+2)-1:0]        divisor,
   input  logic signed [SAMPLE_WIDTH-1:0]       sample,
   output cwa_pkg::lane_stat_type               stat,
   output logic signed [SAMPLE_WIDTH-1:0]       avg
);

   localparam int DEPTH = 2 * RADIUS + 1;
   localparam int D_W   = $clog2(DEPTH + 1);
   localparam int SUM_W = SAMPLE_WIDTH + $clog2(DEPTH);
   localparam int BPS   = cwa_pkg::DIV_BITS_PER_CYCLE;
   localparam int ITERS = (SUM_W + BPS - 1) / BPS;
   localparam int QW    = ITERS * BPS;
   localparam int CNT_W = $clog2(ITERS + 1);

   logic signed [SAMPLE_WIDTH-1:0] win_ff [DEPTH];
   logic signed [SAMPLE_WIDTH-1:0] win_in [DEPTH];
   logic signed [SUM_W-1:0]        total_ff, total_in;
   logic signed [SUM_W-1:0]        part_ff, part_in;
   logic signed [SUM_W-1:0]        drop_val;
   logic [D_W-1:0]                 div_ff, div_in;
   logic                           neg_ff, neg_in;
   logic                           prep_ff, prep_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [QW-1:0]                  quo_ff, quo_in;
   logic [D_W-1:0]                 rem_ff, rem_in;
   logic [SUM_W-1:0]               half_p1;
   logic [SUM_W-1:0]               mag;
   logic [D_W:0]                   trial;
   logic [QW-1:0]                  q_work;
   logic [D_W-1:0]                 r_work;
   logic [SAMPLE_WIDTH-1:0]        q_low;

   always_comb begin
      win_in   = win_ff;
      total_in = total_ff;
      if (ctrl.clear) begin
         for (int k = 0; k < DEPTH; k++) begin
            win_in[k] = '0;
         end
         total_in = '0;
      end else if (ctrl.push) begin
         win_in[0] = sample;
         for (int k = 1; k < DEPTH; k++) begin
            win_in[k] = win_ff[k-1];
         end
         total_in = total_ff + SUM_W'(sample) - SUM_W'(win_ff[DEPTH-1]);
      end
   end

   always_comb begin
      drop_val = ctrl.drop ? SUM_W'(win_ff[drop_index]) : '0;
      part_in  = part_ff;
      div_in   = div_ff;
      if (ctrl.start) begin
         part_in = ctrl.use_total ? total_ff : (part_ff - drop_val);
         div_in  = divisor;
      end
   end

   always_comb begin
      half_p1 = SUM_W'(div_ff >> 1) + SUM_W'(1);
      if (part_ff[SUM_W-1]) begin
         mag = ~part_ff + half_p1;
      end else begin
         mag = part_ff + SUM_W'(div_ff >> 1);
      end
   end

   always_comb begin
      q_work  = quo_ff;
      r_work  = rem_ff;
      trial   = '0;
      for (int s = 0; s < BPS; s++) begin
         trial  = {r_work, q_work[QW-1]};
         q_work = q_work << 1;
         if (trial >= {1'b0, div_ff}) begin
            r_work    = D_W'(trial - {1'b0, div_ff});
            q_work[0] = 1'b1;
         end else begin
            r_work = trial[D_W-1:0];
         end
      end
   end

   always_comb begin
      prep_in = prep_ff;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      neg_in  = neg_ff;
      if (ctrl.start) begin
         prep_in = 1'b1;
      end else if (prep_ff) begin
         prep_in = 1'b0;
         quo_in  = QW'(mag);
         rem_in  = '0;
         neg_in  = part_ff[SUM_W-1];
         cnt_in  = CNT_W'(ITERS);
      end else if (cnt_ff != '0) begin
         quo_in = q_work;
         rem_in = r_work;
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '{default: '0};
         total_ff <= '0;
         prep_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         win_ff   <= win_in;
         total_ff <= total_in;
         prep_ff  <= prep_in;
         cnt_ff   <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      part_ff <= part_in;
      div_ff  <= div_in;
      neg_ff  <= neg_in;
      quo_ff  <= quo_in;
      rem_ff  <= rem_in;
   end

   assign q_low     = quo_ff[SAMPLE_WIDTH-1:0];
   assign avg       = neg_ff ? -$signed(q_low) : $signed(q_low);
   assign stat.busy = prep_ff || (cnt_ff != '0);

   `CWA_ASSERT_NEVER(a_push_while_dividing, ctrl.push && stat.busy, "sample pushed during division")
   `CWA_ASSERT(a_result_held_when_idle, (!stat.busy && !ctrl.start) |=> $stable(quo_ff), "idle quotient changed")

endmodule

/* design/cwa_merge.sv */
// ----------------------------------------------------------------------------
// Centered window average merge stage
// Packs the two lane means into one result word and holds it for the consumer.
// ----------------------------------------------------------------------------
module cwa_merge #(
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                          clock,
   input  logic                                          reset,
   input  cwa_pkg::merge_ctrl_type                       mctrl,
   input  logic signed [SAMPLE_WIDTH-1:0]                avg_plus,
   input  logic signed [SAMPLE_WIDTH-1:0]                avg_minus,
   output logic                                          free,
   output logic                                          rsp_tvalid,
   input  logic                                          rsp_tready,
   // Fields from the lowest bit up: avg_plus, avg_minus, zero fill.
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]           rsp_tdata,
   output logic                                          rsp_tlast
);

   localparam int DATA_W = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;

   logic              valid_ff, valid_in;
   logic [DATA_W-1:0] data_ff, data_in;
   logic              last_ff, last_in;

   always_comb begin
      free     = !valid_ff || rsp_tready;
      valid_in = valid_ff && !rsp_tready;
      data_in  = data_ff;
      last_in  = last_ff;
      if (mctrl.load) begin
         valid_in = 1'b1;
         data_in  = DATA_W'({avg_minus, avg_plus});
         last_in  = mctrl.fin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata  = data_ff;
   assign rsp_tlast  = last_ff;

endmodule

/* design/centered_window_average_unit.sv */
// ----------------------------------------------------------------------------
// Centered window average unit
// Two-channel centered moving average with truncated edges and rounded means.
// ----------------------------------------------------------------------------
// Each sample word feeds two identical lanes, one per channel, and a result
// word gives the mean of the samples within RADIUS positions, lagging RADIUS
// words behind; the word with tlast flushes up to RADIUS+1 results, the final
// one with tlast set, and starts a new sequence. A word that yields no result
// leaves the unit idle and ready for the next word. Each lane divides with a
// divider that retires four quotient bits per cycle, and no new word is taken
// while a result is being formed. The result register lets a new word enter
// while the previous result waits. No clearing pass follows reset.
`include "centered_window_average_unit_macros.svh"

module centered_window_average_unit #(
   parameter int RADIUS       = 3,
   parameter int SAMPLE_WIDTH = 24
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_tvalid,
   output logic                                  req_tready,
   // Fields from the lowest bit up: sig_plus, sig_minus, zero fill.
   input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   req_tdata,
   input  logic                                  req_tlast,
   output logic                                  rsp_tvalid,
   input  logic                                  rsp_tready,
   // Fields from the lowest bit up: avg_plus, avg_minus, zero fill.
   output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0]   rsp_tdata,
   output logic                                  rsp_tlast
);

   localparam int DEPTH = 2 * RADIUS + 1;
   localparam int IDX_W = $clog2(DEPTH);
   localparam int D_W   = $clog2(DEPTH + 1);
   localparam int C_W   = $clog2(RADIUS + 1);

   cwa_pkg::cwa_state_type  state_ff, state_in;
   logic [D_W-1:0]          n_ff, n_in;
   logic [IDX_W-1:0]        hi_ff, hi_in;
   logic [IDX_W-1:0]        top_ff, top_in;
   logic [C_W-1:0]          c_ff, c_in;
   logic                    flush_ff, flush_in;
   logic                    first_ff, first_in;
   logic                    drop_ff, drop_in;
   logic [IDX_W-1:0]        didx_ff, didx_in;

   logic                    accept;
   logic [D_W-1:0]          n_new;
   logic [D_W-1:0]          nm1;
   logic [C_W-1:0]          c_next;
   logic [IDX_W-1:0]        reach;
   logic [IDX_W-1:0]        hi_next;
   logic [D_W-1:0]          divisor;

   cwa_pkg::lane_ctrl_type  ctrl;
   cwa_pkg::lane_stat_type  lane_stat [2];
   logic signed [SAMPLE_WIDTH-1:0] lane_avg [2];
   cwa_pkg::merge_ctrl_type mctrl;
   logic                    out_free;

   assign accept  = req_tvalid && req_tready;
   assign n_new   = (n_ff < D_W'(DEPTH)) ? (n_ff + D_W'(1)) : n_ff;
   assign nm1     = n_new - D_W'(1);
   assign c_next  = c_ff - C_W'(1);
   assign reach   = IDX_W'(c_next) + IDX_W'(RADIUS);
   assign hi_next = (reach < top_ff) ? reach : top_ff;
   assign divisor = D_W'(hi_ff) + D_W'(1);

   always_comb begin
      state_in   = state_ff;
      n_in       = n_ff;
      hi_in      = hi_ff;
      top_in     = top_ff;
      c_in       = c_ff;
      flush_in   = flush_ff;
      first_in   = first_ff;
      drop_in    = drop_ff;
      didx_in    = didx_ff;
      ctrl       = '0;
      mctrl      = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         cwa_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            if (accept) begin
               ctrl.push = 1'b1;
               n_in      = n_new;
               hi_in     = IDX_W'(nm1);
               top_in    = IDX_W'(nm1);
               c_in      = (nm1 < D_W'(RADIUS)) ? C_W'(nm1) : C_W'(RADIUS);
               flush_in  = req_tlast;
               first_in  = 1'b1;
               drop_in   = 1'b0;
               if (req_tlast || (n_new >= D_W'(RADIUS + 1))) begin
                  state_in = cwa_pkg::ST_LOAD;
               end
            end
         end
         cwa_pkg::ST_LOAD: begin
            ctrl.start     = 1'b1;
            ctrl.use_total = first_ff;
            ctrl.drop      = drop_ff;
            state_in       = cwa_pkg::ST_DIVIDE;
         end
         cwa_pkg::ST_DIVIDE: begin
            if (!lane_stat[0].busy && out_free) begin
               mctrl.load = 1'b1;
               mctrl.fin  = flush_ff && (c_ff == '0);
               if (flush_ff && (c_ff != '0)) begin
                  c_in     = c_next;
                  hi_in    = hi_next;
                  drop_in  = (hi_next != hi_ff);
                  didx_in  = hi_ff;
                  first_in = 1'b0;
                  state_in = cwa_pkg::ST_LOAD;
               end else begin
                  if (flush_ff) begin
                     ctrl.clear = 1'b1;
                     n_in       = '0;
                     flush_in   = 1'b0;
                  end
                  state_in = cwa_pkg::ST_IDLE;
               end
            end
         end
         default: begin
            state_in = cwa_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cwa_pkg::ST_IDLE;
         n_ff     <= '0;
         flush_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         n_ff     <= n_in;
         flush_ff <= flush_in;
      end
   end

   always_ff @(posedge clock) begin
      hi_ff    <= hi_in;
      top_ff   <= top_in;
      c_ff     <= c_in;
      first_ff <= first_in;
      drop_ff  <= drop_in;
      didx_ff  <= didx_in;
   end

   for (genvar i = 0; i < 2; i++) begin : g_lane
      cwa_lane #(
         .RADIUS       (RADIUS),
         .SAMPLE_WIDTH (SAMPLE_WIDTH)
      ) u_lane (
         .clock      (clock),
         .reset      (reset),
         .ctrl       (ctrl),
         .drop_index (didx_ff),
         .divisor    (divisor),
         .sample     ($signed(req_tdata[i*SAMPLE_WIDTH +: SAMPLE_WIDTH])),
         .stat       (lane_stat[i]),
         .avg        (lane_avg[i])
      );
   end

   cwa_merge #(
      .SAMPLE_WIDTH (SAMPLE_WIDTH)
   ) u_merge (
      .clock      (clock),
      .reset      (reset),
      .mctrl      (mctrl),
      .avg_plus   (lane_avg[0]),
      .avg_minus  (lane_avg[1]),
      .free       (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   `CWA_ASSERT(a_lanes_lockstep, lane_stat[0].busy == lane_stat[1].busy, "lanes out of step")
   `CWA_ASSERT(a_load_starts_lanes, (state_ff == cwa_pkg::ST_LOAD) |=> lane_stat[0].busy, "lanes idle after load")
   `CWA_ASSERT(a_final_clears_count, (mctrl.load && mctrl.fin) |=> (n_ff == '0), "count kept after final result")

endmodule

/* verif/tb_centered_window_average_unit.sv */
// ----------------------------------------------------------------------------
// Testbench for the centered window average unit
// Drives two-channel sample words in runs closed by tlast, with random gaps on
// both sides and one long receiver hold-off. A model of the centered window
// with truncated edges and rounded means predicts every result word, and each
// accepted result word is compared field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_centered_window_average_unit;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int RADIUS       = 3;
   localparam int SAMPLE_WIDTH = 24;
   localparam int DEPTH        = 2 * RADIUS + 1;
   localparam int WORD_BITS    = ((2 * SAMPLE_WIDTH + 7) / 8) * 8;
   localparam int CYCLE_LIMIT  = 500000;
   localparam int TAIL_CYCLES  = 60;

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;

   typedef struct {
      sample_type avg_plus;
      sample_type avg_minus;
      logic       last_res;
   } mean_word_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [WORD_BITS-1:0] req_tdata = '0;
   logic                 req_tlast = 1'b0;
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [WORD_BITS-1:0] rsp_tdata;
   logic                 rsp_tlast;

   logic                 rsp_hold = 1'b0;
   int                   send_gap_max = 14;
   int                   recv_gap_max = 14;
   int                   recv_wait = 0;
   int                   error_count = 0;
   int                   cycle_count = 0;

   sample_type           hist_plus [DEPTH];
   sample_type           hist_minus[DEPTH];
   int                   hist_count = 0;
   mean_word_type        pending_means[$];

   centered_window_average_unit #(
      .RADIUS      (RADIUS),
      .SAMPLE_WIDTH(SAMPLE_WIDTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tlast (req_tlast),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++) @(posedge clock);
      $display("%0t: run did not finish within %0d cycles", $time, CYCLE_LIMIT);
      $display("*** FAILED ***");
      $finish;
   end

   function automatic sample_type rounded_mean(longint total, int count);
      longint mag;
      longint quo;
      mag = (total < 0) ? -total : total;
      quo = (mag + count / 2) / count;
      return (total < 0) ? sample_type'(-quo) : sample_type'(quo);
   endfunction

   function automatic void push_mean(int hi, logic fin);
      longint        sum_plus;
      longint        sum_minus;
      mean_word_type word;
      sum_plus  = 0;
      sum_minus = 0;
      for (int k = 0; k <= hi; k++) begin
         sum_plus  += hist_plus[k];
         sum_minus += hist_minus[k];
      end
      word.avg_plus  = rounded_mean(sum_plus, hi + 1);
      word.avg_minus = rounded_mean(sum_minus, hi + 1);
      word.last_res  = fin;
      pending_means.push_back(word);
   endfunction

   function automatic void clear_history();
      for (int k = 0; k < DEPTH; k++) begin
         hist_plus[k]  = '0;
         hist_minus[k] = '0;
      end
      hist_count = 0;
   endfunction

   function automatic void track_sample(sample_type plus, sample_type minus, logic fin);
      int held;
      int pos;
      int hi;
      for (int k = DEPTH - 1; k > 0; k--) begin
         hist_plus[k]  = hist_plus[k-1];
         hist_minus[k] = hist_minus[k-1];
      end
      hist_plus[0]  = plus;
      hist_minus[0] = minus;
      if (hist_count < DEPTH) hist_count++;
      held = hist_count;
      if (!fin) begin
         if (held >= RADIUS + 1) push_mean(held - 1, 1'b0);
      end else begin
         pos = (held - 1 < RADIUS) ? held - 1 : RADIUS;
         for (; pos >= 0; pos--) begin
            hi = (pos + RADIUS > held - 1) ? held - 1 : pos + RADIUS;
            push_mean(hi, pos == 0);
         end
         clear_history();
      end
   endfunction

   task automatic compare_mean(logic [WORD_BITS-1:0] data, logic fin);
      mean_word_type want;
      sample_type    got_plus;
      sample_type    got_minus;
      got_plus  = data[SAMPLE_WIDTH-1:0];
      got_minus = data[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
      if (pending_means.size() == 0) begin
         $display("%0t: result word with none expected: plus %0d minus %0d last %0b",
                  $time, got_plus, got_minus, fin);
         error_count++;
      end else begin
         want = pending_means.pop_front();
         if (got_plus !== want.avg_plus) begin
            $display("%0t: avg_plus expected %0d, got %0d", $time, want.avg_plus, got_plus);
            error_count++;
         end
         if (got_minus !== want.avg_minus) begin
            $display("%0t: avg_minus expected %0d, got %0d", $time, want.avg_minus, got_minus);
            error_count++;
         end
         if (fin !== want.last_res) begin
            $display("%0t: last_res expected %0b, got %0b", $time, want.last_res, fin);
            error_count++;
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            compare_mean(rsp_tdata, rsp_tlast);
            recv_wait = $urandom_range(recv_gap_max, 0);
         end
         if (rsp_hold || recv_wait > 0) begin
            rsp_tready <= 1'b0;
            if (!rsp_hold) recv_wait--;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   task automatic hold_off(int cycles);
      rsp_hold <= 1'b1;
      repeat (cycles) @(posedge clock);
      rsp_hold <= 1'b0;
   endtask

   task automatic send_sample(sample_type plus, sample_type minus, logic fin);
      int gap;
      req_tvalid <= 1'b1;
      req_tdata  <= {minus, plus};
      req_tlast  <= fin;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      track_sample(plus, minus, fin);
      gap = $urandom_range(send_gap_max, 0);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_means.size() != 0) @(posedge clock);
   endtask

   function automatic sample_type pick_sample();
      case ($urandom_range(15, 0))
         0:       return SAMPLE_MAX;
         1:       return SAMPLE_MIN;
         2:       return '0;
         3:       return '1;
         default: return sample_type'($urandom);
      endcase
   endfunction

   task automatic send_run(int length);
      for (int i = 0; i < length; i++) begin
         send_sample(pick_sample(), pick_sample(), i == length - 1);
      end
   endtask

   task automatic test_short_runs();
      for (int length = 1; length <= RADIUS; length++) send_run(length);
      wait_drained();
   endtask

   task automatic test_extremes();
      for (int i = 0; i < 4; i++) send_sample(SAMPLE_MAX, SAMPLE_MIN, i == 3);
      for (int i = 0; i < 5; i++) begin
         send_sample(i[0] ? SAMPLE_MIN : SAMPLE_MAX, i[0] ? SAMPLE_MAX : SAMPLE_MIN, i == 4);
      end
      wait_drained();
   endtask

   task automatic test_rounding_ties();
      for (int i = 0; i < 6; i++) begin
         send_sample((i < 2) ? sample_type'(1) : sample_type'(0),
                     (i < 2) ? sample_type'(-1) : sample_type'(0), i == 5);
      end
      wait_drained();
   endtask

   task automatic test_steady_stream();
      send_gap_max = 0;
      recv_gap_max = 0;
      send_run(60);
      wait_drained();
      send_gap_max = 14;
      recv_gap_max = 14;
   endtask

   task automatic test_backpressure();
      send_gap_max = 0;
      fork
         hold_off(400);
      join_none
      send_run(41);
      wait_drained();
      send_gap_max = 14;
   endtask

   task automatic test_mid_run_pause();
      for (int i = 0; i < 10; i++) send_sample(pick_sample(), pick_sample(), 1'b0);
      wait_drained();
      for (int i = 0; i < 6; i++) send_sample(pick_sample(), pick_sample(), i == 5);
      wait_drained();
   endtask

   task automatic test_random_runs();
      int sent;
      int length;
      sent = 0;
      while (sent < 360) begin
         send_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 14;
         recv_gap_max = ($urandom_range(3, 0) == 0) ? 0 : 14;
         length = ($urandom_range(3, 0) == 0) ? $urandom_range(40, 13) : $urandom_range(12, 1);
         send_run(length);
         sent += length;
         if ($urandom_range(7, 0) == 0) wait_drained();
      end
   endtask

   initial begin
      clear_history();
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      test_short_runs();
      test_extremes();
      test_rounding_ties();
      test_steady_stream();
      test_backpressure();
      test_mid_run_pause();
      test_random_runs();
      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (pending_means.size() != 0) begin
         $display("%0t: %0d result words never arrived", $time, pending_means.size());
         error_count++;
      end
      if (error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
